// ===== rtl/core/counting_sort_row_stats_macros.svh =====
// Assertion helpers used by the sorter back end (csrs_back).
`ifndef COUNTING_SORT_ROW_STATS_MACROS_SVH
`define COUNTING_SORT_ROW_STATS_MACROS_SVH

`ifndef SYNTHESIS
`define CSRS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CSRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CSRS_ASSERT_IMPL(label, ante, cons, msg)
`define CSRS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/core/csrs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package csrs_pkg;

    localparam int KEY_W         = 7;
    localparam int COUNT_W       = 7;
    localparam int MED_W         = 8;
    localparam int KEY_SPAN      = 128;
    localparam int KEY_RANGE_DEF = 128;
    localparam int MAX_ROW_DEF   = 64;
    localparam int QUEUE_DEPTH   = 4;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             last;
    } t_in_item;

    typedef struct packed {
        logic [KEY_W-1:0] sorted_key;
        logic             end_of_row;
        logic [KEY_W-1:0] row_min;
        logic [KEY_W-1:0] row_max;
        logic [MED_W-1:0] median_twice;
        logic             overflow;
    } t_out_item;

    // One queued command: count a key, close the row, or both.
    typedef struct packed {
        logic               do_count;
        logic               close;
        logic [KEY_W-1:0]   key;
        logic [KEY_W-1:0]   row_min;
        logic [KEY_W-1:0]   row_max;
        logic [COUNT_W-1:0] n;
        logic               overflow;
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/core/csrs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/csrs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csrs_front
    import csrs_pkg::*;
#(
    parameter int KEY_RANGE = KEY_RANGE_DEF,
    parameter int MAX_ROW   = MAX_ROW_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_word,
    input  wire logic     i_q_full,
    input  wire logic     i_clearing,
    output logic          o_q_push,
    output t_cmd          o_q_cmd
);

    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_ovf, n_ovf;
    logic [KEY_W-1:0]   r_min, n_min;
    logic [KEY_W-1:0]   r_max, n_max;
    logic [KEY_W-1:0]   key_sat;
    logic               accept;
    logic               room;

    always_comb begin
        o_in_stall = i_q_full || i_clearing;
        accept     = i_in_valid && !o_in_stall;

        // Keys past the configured range land in the top bin.
        if ({{(32-KEY_W){1'b0}}, i_in_word.key} >= 32'(KEY_RANGE)) begin
            key_sat = KEY_W'(KEY_RANGE - 1);
        end else begin
            key_sat = i_in_word.key;
        end

        room    = r_count < COUNT_W'(MAX_ROW);
        n_count = room ? r_count + 1'b1 : r_count;
        n_ovf   = r_ovf || !room;
        n_min   = (room && key_sat < r_min) ? key_sat : r_min;
        n_max   = (room && key_sat > r_max) ? key_sat : r_max;

        o_q_push         = accept && (room || i_in_word.last);
        o_q_cmd.do_count = room;
        o_q_cmd.close    = i_in_word.last;
        o_q_cmd.key      = key_sat;
        o_q_cmd.row_min  = n_min;
        o_q_cmd.row_max  = n_max;
        o_q_cmd.n        = n_count;
        o_q_cmd.overflow = n_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_min   <= '1;
            r_max   <= '0;
        end else if (accept) begin
            if (i_in_word.last) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
                r_min   <= '1;
                r_max   <= '0;
            end else begin
                r_count <= n_count;
                r_ovf   <= n_ovf;
                r_min   <= n_min;
                r_max   <= n_max;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/csrs_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csrs_queue
    import csrs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_cmd      o_head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    always_comb begin
        o_full  = r_count == CNT_W'(QUEUE_DEPTH);
        o_empty = r_count == '0;
        o_head  = r_mem[r_rd];
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/csrs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "counting_sort_row_stats_macros.svh"

module csrs_back
    import csrs_pkg::*;
#(
    parameter int KEY_RANGE = KEY_RANGE_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_q_empty,
    input  wire t_cmd      i_q_head,
    output logic           o_q_pop,
    output logic           o_clearing,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_word
);

    localparam int BINS  = (KEY_RANGE < KEY_SPAN) ? KEY_RANGE : KEY_SPAN;
    localparam int BIN_W = $clog2(BINS);

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_C_RD,
        ST_C_WR,
        ST_M_RD,
        ST_M_ACC,
        ST_E_RD,
        ST_E_LD,
        ST_E_EMIT
    } t_state;

    t_state             r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [BIN_W-1:0]   r_b, n_b;
    logic [COUNT_W-1:0] r_cum, n_cum;
    logic [BIN_W-1:0]   r_lo, n_lo;
    logic [BIN_W-1:0]   r_hi, n_hi;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic [COUNT_W-1:0] r_left, n_left;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out_word, n_out_word;

    logic               ram_we;
    logic [BIN_W-1:0]   ram_waddr;
    logic [COUNT_W-1:0] ram_wdata;
    logic [BIN_W-1:0]   ram_raddr;
    logic [COUNT_W-1:0] ram_rdata;

    logic               out_free;
    logic [BIN_W-1:0]   cmd_bin;
    logic [BIN_W-1:0]   bin_min;
    logic [BIN_W-1:0]   bin_max;
    logic [COUNT_W-1:0] lo_idx;
    logic [COUNT_W-1:0] hi_idx;
    logic [COUNT_W:0]   cum_end;

    csrs_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (BINS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_b         = r_b;
        n_cum       = r_cum;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;

        ram_we    = 1'b0;
        ram_waddr = r_b;
        ram_wdata = '0;
        ram_raddr = r_b;
        o_q_pop   = 1'b0;

        out_free = !r_out_valid || !i_out_stall;
        if (out_free) begin
            n_out_valid = 1'b0;
        end

        cmd_bin = BIN_W'(r_cmd.key);
        bin_min = BIN_W'(r_cmd.row_min);
        bin_max = BIN_W'(r_cmd.row_max);
        // The two middle ranks coincide for an odd count.
        lo_idx  = (r_cmd.n - 1'b1) >> 1;
        hi_idx  = r_cmd.n >> 1;
        cum_end = {1'b0, r_cum} + {1'b0, ram_rdata};

        case (r_state)
            ST_CLR: begin
                ram_we = 1'b1;
                if (r_b == BIN_W'(BINS - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_b = r_b + 1'b1;
                end
            end
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_head;
                    n_b     = BIN_W'(i_q_head.row_min);
                    n_cum   = '0;
                    n_state = i_q_head.do_count ? ST_C_RD : ST_M_RD;
                end
            end
            ST_C_RD: begin
                ram_raddr = cmd_bin;
                n_state   = ST_C_WR;
            end
            ST_C_WR: begin
                ram_we    = 1'b1;
                ram_waddr = cmd_bin;
                ram_wdata = ram_rdata + 1'b1;
                n_state   = r_cmd.close ? ST_M_RD : ST_IDLE;
            end
            ST_M_RD: begin
                n_state = ST_M_ACC;
            end
            ST_M_ACC: begin
                if ({1'b0, r_cum} <= {1'b0, lo_idx} && {1'b0, lo_idx} < cum_end) begin
                    n_lo = r_b;
                end
                if ({1'b0, r_cum} <= {1'b0, hi_idx} && {1'b0, hi_idx} < cum_end) begin
                    n_hi = r_b;
                end
                n_cum = COUNT_W'(cum_end);
                if (r_b == bin_max) begin
                    n_b     = bin_min;
                    n_left  = r_cmd.n;
                    n_state = ST_E_RD;
                end else begin
                    n_b     = r_b + 1'b1;
                    n_state = ST_M_RD;
                end
            end
            ST_E_RD: begin
                n_state = ST_E_LD;
            end
            ST_E_LD: begin
                // Take the bin's count and clear the bin for the next row.
                n_cnt   = ram_rdata;
                ram_we  = 1'b1;
                n_state = ST_E_EMIT;
            end
            ST_E_EMIT: begin
                if (r_cnt == '0) begin
                    if (r_b == bin_max) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_b     = r_b + 1'b1;
                        n_state = ST_E_RD;
                    end
                end else if (out_free) begin
                    n_out_valid             = 1'b1;
                    n_out_word.sorted_key   = KEY_W'(r_b);
                    n_out_word.end_of_row   = r_left == COUNT_W'(1);
                    n_out_word.row_min      = r_cmd.row_min;
                    n_out_word.row_max      = r_cmd.row_max;
                    n_out_word.median_twice = MED_W'(r_lo) + MED_W'(r_hi);
                    n_out_word.overflow     = r_cmd.overflow;
                    n_cnt                   = r_cnt - 1'b1;
                    n_left                  = r_left - 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        o_clearing  = r_state == ST_CLR;
        o_out_valid = r_out_valid;
        o_out_word  = r_out_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_b         <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_b         <= n_b;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
        r_cmd      <= n_cmd;
        r_cum      <= n_cum;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_cnt      <= n_cnt;
        r_out_word <= n_out_word;
    end

    `CSRS_ASSERT_IMPL(a_left_covers_bin, (r_state == ST_E_EMIT) && (r_cnt != '0), r_left != '0, "bin holds more keys than the row has left")
    `CSRS_ASSERT_IMPL(a_scan_in_range, (r_state == ST_M_ACC) || (r_state == ST_E_LD), r_b <= bin_max, "histogram scan ran past the row maximum")
    `CSRS_ASSERT_IMPL(a_idle_row_done, r_state == ST_IDLE, r_left == '0, "back end went idle with keys still owed")
    `CSRS_ASSERT_NEXT(a_clear_blocks_pop, r_state == ST_CLR, !o_q_pop, "queue popped during the histogram clear")

endmodule

`default_nettype wire

// ===== rtl/core/counting_sort_row_stats.sv =====
// Output: a row's first sorted word follows its last accepted word once the back end
// has counted the row's queued keys (that last key too, unless it is dropped) and has
// scanned its bins from row_min to row_max, all through the single histogram RAM that
// counts, scans and clears one bin at a time. The input stalls when the queue is full.
// Reset: synchronous, active low; control clears, then the histogram is zeroed one bin
// per cycle over all min(KEY_RANGE, 128) bins, during which the input is stalled.
`timescale 1ns / 1ps
`default_nettype none

module counting_sort_row_stats
    import csrs_pkg::*;
#(
    parameter int KEY_RANGE = KEY_RANGE_DEF,
    parameter int MAX_ROW   = MAX_ROW_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_word
);

    logic q_push;
    t_cmd q_cmd;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_cmd q_head;
    logic clearing;

    csrs_front #(
        .KEY_RANGE (KEY_RANGE),
        .MAX_ROW   (MAX_ROW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .i_q_full   (q_full),
        .i_clearing (clearing),
        .o_q_push   (q_push),
        .o_q_cmd    (q_cmd)
    );

    csrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    csrs_back #(
        .KEY_RANGE (KEY_RANGE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

// ===== tb/counting_sort_row_stats_checker.sv =====
`timescale 1ns / 1ps

module counting_sort_row_stats_checker
    import csrs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_item    i_in_word,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_item   i_out_word,
    output int unsigned o_fail_count,
    output int unsigned o_pending,
    output int unsigned o_keys_seen,
    output int unsigned o_rows_closed,
    output int unsigned o_overflow_rows,
    output int unsigned o_words_checked
);

    logic [COUNT_W-1:0] bin_count [KEY_SPAN];
    int unsigned        row_keys;
    logic               row_overflow;
    logic [KEY_W-1:0]   row_lo;
    logic [KEY_W-1:0]   row_hi;
    t_out_item          sorted_q [$];

    function automatic void clear_row_state();
        for (int b = 0; b < KEY_SPAN; b++) begin
            bin_count[b] = '0;
        end
        row_keys     = 0;
        row_overflow = 1'b0;
        row_lo       = KEY_W'(127);
        row_hi       = '0;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic compare_field(input string name, input logic [MED_W-1:0] got,
                                 input logic [MED_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h, expected %0h (word %0d)",
                                      name, got, want, o_words_checked));
        end
    endtask

    // Closing a row walks the bins in ascending order; one word per counted key.
    task automatic emit_sorted_row();
        logic [KEY_W-1:0] sorted_keys [MAX_ROW_DEF];
        int unsigned      n;
        logic [MED_W-1:0] med2;
        t_out_item        word;
        n = 0;
        for (int b = 0; b < KEY_SPAN; b++) begin
            for (int c = 0; c < bin_count[b] && n < MAX_ROW_DEF; c++) begin
                sorted_keys[n] = KEY_W'(b);
                n++;
            end
        end
        if (n != 0) begin
            if (n % 2 == 1) begin
                med2 = MED_W'(sorted_keys[n / 2]) + MED_W'(sorted_keys[n / 2]);
            end else begin
                med2 = MED_W'(sorted_keys[n / 2 - 1]) + MED_W'(sorted_keys[n / 2]);
            end
            for (int k = 0; k < n; k++) begin
                word.sorted_key   = sorted_keys[k];
                word.end_of_row   = (k + 1 == n);
                word.row_min      = row_lo;
                word.row_max      = row_hi;
                word.median_twice = med2;
                word.overflow     = row_overflow;
                sorted_q.push_back(word);
            end
        end
        o_rows_closed++;
        if (row_overflow) begin
            o_overflow_rows++;
        end
        clear_row_state();
    endtask

    task automatic take_key(input t_in_item w);
        o_keys_seen++;
        if (row_keys < MAX_ROW_DEF) begin
            bin_count[w.key] = bin_count[w.key] + 1'b1;
            row_keys++;
            if (w.key < row_lo) begin
                row_lo = w.key;
            end
            if (w.key > row_hi) begin
                row_hi = w.key;
            end
        end else begin
            row_overflow = 1'b1;
        end
        if (w.last) begin
            emit_sorted_row();
        end
    endtask

    task automatic check_word(input t_out_item got);
        t_out_item want;
        if (sorted_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word with key %0h", got.sorted_key));
        end else begin
            want = sorted_q.pop_front();
            compare_field("sorted_key", MED_W'(got.sorted_key), MED_W'(want.sorted_key));
            compare_field("end_of_row", MED_W'(got.end_of_row), MED_W'(want.end_of_row));
            compare_field("row_min", MED_W'(got.row_min), MED_W'(want.row_min));
            compare_field("row_max", MED_W'(got.row_max), MED_W'(want.row_max));
            compare_field("median_twice", got.median_twice, want.median_twice);
            compare_field("overflow", MED_W'(got.overflow), MED_W'(want.overflow));
            o_words_checked++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_row_state();
            sorted_q.delete();
            o_fail_count    = 0;
            o_keys_seen     = 0;
            o_rows_closed   = 0;
            o_overflow_rows = 0;
            o_words_checked = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_word(i_out_word);
            end
            if (i_in_valid && !i_in_stall) begin
                take_key(i_in_word);
            end
        end
        o_pending <= sorted_q.size();
    end

endmodule

// ===== tb/counting_sort_row_stats_tb.sv =====
`timescale 1ns / 1ps

module counting_sort_row_stats_tb;
    import csrs_pkg::*;

    localparam int TOTAL_KEYS   = 370;
    localparam int HOLD_START   = 400;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 600;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_EVERY_THIRD
    } t_stall_mode;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_word   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_word;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned keys_seen;
    int unsigned rows_closed;
    int unsigned overflow_rows;
    int unsigned words_checked;

    int burst_left = 0;
    int keys_sent  = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    counting_sort_row_stats u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    counting_sort_row_stats_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_word       (in_word),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_word      (out_word),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_keys_seen     (keys_seen),
        .o_rows_closed   (rows_closed),
        .o_overflow_rows (overflow_rows),
        .o_words_checked (words_checked)
    );

    // Valid stays high across a burst; a gap only opens once the burst is used up.
    task automatic offer_key(input logic [KEY_W-1:0] key, input logic last);
        t_in_item w;
        int       gap;
        w.key  = key;
        w.last = last;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        burst_left--;
        keys_sent++;
    endtask

    task automatic offer_row(input int keys [$]);
        for (int i = 0; i < keys.size(); i++) begin
            offer_key(KEY_W'(keys[i]), i == keys.size() - 1);
        end
    endtask

    // Narrow key windows give many repeated keys; the full window spreads the row.
    task automatic offer_random_row(input int len);
        int span;
        int base;
        case ($urandom_range(0, 3))
            0: span = 1;
            1: span = 4;
            2: span = 16;
            default: span = KEY_SPAN;
        endcase
        base = $urandom_range(0, KEY_SPAN - span);
        for (int i = 0; i < len; i++) begin
            offer_key(KEY_W'(base + $urandom_range(0, span - 1)), i == len - 1);
        end
    endtask

    initial begin
        int row [$];
        int row_num;
        int len;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        row = {0};
        offer_row(row);
        row = {127};
        offer_row(row);
        row = {127, 0};
        offer_row(row);
        row = {5, 3, 5, 9, 1};
        offer_row(row);
        row = {42, 42, 42};
        offer_row(row);
        row = {1, 126, 64, 2};
        offer_row(row);

        // The first random rows fill the row exactly, and past its capacity with
        // the closing key among the dropped ones.
        row_num = 0;
        while (keys_sent < TOTAL_KEYS) begin
            case (row_num)
                0: len = 66;
                1: len = MAX_ROW_DEF;
                2: len = 65;
                default: begin
                    if ($urandom_range(0, 9) == 0) begin
                        len = $urandom_range(60, 70);
                    end else begin
                        len = $urandom_range(1, 12);
                    end
                end
            endcase
            offer_random_row(len);
            row_num++;
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d keys in %0d rows, %0d of them over capacity,",
                 keys_seen, rows_closed, overflow_rows);
        $display("with %0d sorted words checked under input gaps and output stalls.",
                 words_checked);
        if (fail_count == 0 && pending == 0) begin
            $display("counting_sort_row_stats_tb passed");
        end else begin
            $display("counting_sort_row_stats_tb failed");
        end
        $finish;
    end

    // The long hold lets the block back up until it stalls its input.
    initial begin
        int          cyc;
        int          stretch;
        t_stall_mode mode;
        cyc     = 0;
        stretch = 0;
        mode    = STALL_NONE;
        forever begin
            @(posedge clk);
            cyc++;
            if (stretch == 0) begin
                mode    = t_stall_mode'($urandom_range(0, 3));
                stretch = $urandom_range(20, 150);
            end
            stretch--;
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES) begin
                out_stall <= 1'b1;
            end else begin
                case (mode)
                    STALL_NONE: out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
                    default: out_stall <= (cyc % 3 == 0);
                endcase
            end
        end
    end

    initial begin
        #1_000_000;
        $display("counting_sort_row_stats_tb failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/csrs_pkg.sv
rtl/core/csrs_ram.sv
rtl/core/csrs_front.sv
rtl/core/csrs_queue.sv
rtl/core/csrs_back.sv
rtl/core/counting_sort_row_stats.sv
tb/counting_sort_row_stats_checker.sv
tb/counting_sort_row_stats_tb.sv
